// File: design/aqdp_pkg.sv
// Shared types, codes and constants of the admission queue with drop policy.
package aqdp_pkg;

  // Fixed field widths of the stream payloads
  localparam int unsigned OP_W     = 2;
  localparam int unsigned HANDLE_W = 16;
  localparam int unsigned STAMP_W  = 32;
  localparam int unsigned EVENT_W  = 3;
  localparam int unsigned COUNT_W  = 6;
  localparam int unsigned S_DATA_W = 48;
  localparam int unsigned M_DATA_W = 64;

  // Configuration port
  localparam int unsigned CFG_IDX_W  = 2;
  localparam int unsigned CFG_DATA_W = 16;
  localparam int unsigned POLICY_W   = 2;
  localparam int unsigned CAP_W      = 6;
  localparam int unsigned LFSR_W     = 16;

  localparam logic [CFG_IDX_W-1:0] REG_DROP_POLICY = 2'd0;
  localparam logic [CFG_IDX_W-1:0] REG_CAPACITY    = 2'd1;
  localparam logic [CFG_IDX_W-1:0] REG_LFSR_SEED   = 2'd2;

  localparam logic [POLICY_W-1:0] POLICY_BLOCK     = 2'd0;
  localparam logic [POLICY_W-1:0] POLICY_DROP_NEW  = 2'd1;
  localparam logic [POLICY_W-1:0] POLICY_DROP_HEAD = 2'd2;
  localparam logic [POLICY_W-1:0] POLICY_RANDOM    = 2'd3;

  localparam logic [CAP_W-1:0]  CAPACITY_RESET = 6'd32;
  localparam logic [LFSR_W-1:0] LFSR_RESET     = 16'hACE1;
  localparam logic [LFSR_W-1:0] LFSR_MASK      = 16'hB400;

  // Operation codes of an input transaction
  localparam logic [OP_W-1:0] OP_ARRIVE  = 2'd0;
  localparam logic [OP_W-1:0] OP_REQUEST = 2'd1;
  localparam logic [OP_W-1:0] OP_FINISH  = 2'd2;

  // Event codes of an output transaction
  localparam logic [EVENT_W-1:0] EV_ACCEPTED     = 3'd0;
  localparam logic [EVENT_W-1:0] EV_REJECTED     = 3'd1;
  localparam logic [EVENT_W-1:0] EV_EVICTED      = 3'd2;
  localparam logic [EVENT_W-1:0] EV_DISPATCHED   = 3'd3;
  localparam logic [EVENT_W-1:0] EV_FULL_RETRY   = 3'd4;
  localparam logic [EVENT_W-1:0] EV_EMPTY        = 3'd5;
  localparam logic [EVENT_W-1:0] EV_FINISHED     = 3'd6;
  localparam logic [EVENT_W-1:0] EV_FINISH_ERROR = 3'd7;

  // Where the handle and stamp of an emitted result come from
  typedef enum logic [1:0] {
    SRC_ITEM = 2'd0,
    SRC_MEM  = 2'd1,
    SRC_ZERO = 2'd2
  } src_t;

  // Commands from the controller to the datapath
  typedef struct packed {
    logic                 load_item;
    logic                 push;
    logic                 pop;
    logic                 pop_tail;
    logic                 run_inc;
    logic                 run_dec;
    logic                 lfsr_step;
    logic                 load_drops;
    logic                 dec_drops;
    logic                 emit;
    logic [EVENT_W-1:0]   emit_event;
    src_t                 emit_src;
    logic                 emit_last;
  } cmd_t;

  // Status from the datapath to the controller
  typedef struct packed {
    logic [OP_W-1:0]     op;
    logic [POLICY_W-1:0] policy;
    logic                full;
    logic                waiting_zero;
    logic                running_zero;
    logic                drops_zero;
    logic                lfsr_bit;
    logic                out_free;
  } sts_t;

endpackage

// File: design/aqdp_ctrl.sv
// Controller state machine of the admission queue: sequences each transaction.
module aqdp_ctrl (
  input  logic          clk,
  input  logic          rst,
  input  logic          in_valid,
  output logic          in_ready,
  input  aqdp_pkg::sts_t sts,
  output aqdp_pkg::cmd_t cmd
);

  typedef enum logic [5:0] {
    ST_IDLE      = 6'b000001,
    ST_DECIDE    = 6'b000010,
    ST_EVICT_RD  = 6'b000100,
    ST_EVICT_OUT = 6'b001000,
    ST_ACCEPT    = 6'b010000,
    ST_DISP_OUT  = 6'b100000
  } state_t;

  state_t state;
  state_t state_next;

  // State register
  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_IDLE;
    end else begin
      state <= state_next;
    end
  end

  assign in_ready = (state == ST_IDLE);

  // Next state and commands
  always_comb begin
    state_next     = state;
    cmd            = '0;
    cmd.emit_src   = aqdp_pkg::SRC_ITEM;
    cmd.emit_event = aqdp_pkg::EV_ACCEPTED;
    unique case (state)
      ST_IDLE: begin
        if (in_valid) begin
          cmd.load_item = 1'b1;
          state_next    = ST_DECIDE;
        end
      end

      ST_DECIDE: begin
        priority if (sts.op == aqdp_pkg::OP_ARRIVE) begin
          priority if (!sts.full) begin
            if (sts.out_free) begin
              cmd.push       = 1'b1;
              cmd.emit       = 1'b1;
              cmd.emit_event = aqdp_pkg::EV_ACCEPTED;
              cmd.emit_last  = 1'b1;
              state_next     = ST_IDLE;
            end
          end else if (sts.policy == aqdp_pkg::POLICY_BLOCK) begin
            if (sts.out_free) begin
              cmd.emit       = 1'b1;
              cmd.emit_event = aqdp_pkg::EV_FULL_RETRY;
              cmd.emit_last  = 1'b1;
              state_next     = ST_IDLE;
            end
          end else if (sts.waiting_zero || sts.policy == aqdp_pkg::POLICY_DROP_NEW) begin
            if (sts.out_free) begin
              cmd.emit       = 1'b1;
              cmd.emit_event = aqdp_pkg::EV_REJECTED;
              cmd.emit_last  = 1'b1;
              state_next     = ST_IDLE;
            end
          end else begin
            cmd.load_drops = 1'b1;
            state_next     = ST_EVICT_RD;
          end
        end else if (sts.op == aqdp_pkg::OP_REQUEST) begin
          if (sts.waiting_zero) begin
            if (sts.out_free) begin
              cmd.emit       = 1'b1;
              cmd.emit_event = aqdp_pkg::EV_EMPTY;
              cmd.emit_src   = aqdp_pkg::SRC_ZERO;
              cmd.emit_last  = 1'b1;
              state_next     = ST_IDLE;
            end
          end else begin
            cmd.pop     = 1'b1;
            cmd.run_inc = 1'b1;
            state_next  = ST_DISP_OUT;
          end
        end else if (sts.op == aqdp_pkg::OP_FINISH) begin
          if (sts.out_free) begin
            cmd.emit      = 1'b1;
            cmd.emit_src  = aqdp_pkg::SRC_ZERO;
            cmd.emit_last = 1'b1;
            if (sts.running_zero) begin
              cmd.emit_event = aqdp_pkg::EV_FINISH_ERROR;
            end else begin
              cmd.emit_event = aqdp_pkg::EV_FINISHED;
              cmd.run_dec    = 1'b1;
            end
            state_next = ST_IDLE;
          end
        end else begin
          // Unused operation code: dropped without a result
          state_next = ST_IDLE;
        end
      end

      ST_EVICT_RD: begin
        // Random drops step the generator and take the end that it picks
        cmd.pop       = 1'b1;
        cmd.dec_drops = 1'b1;
        if (sts.policy == aqdp_pkg::POLICY_RANDOM) begin
          cmd.lfsr_step = 1'b1;
          cmd.pop_tail  = sts.lfsr_bit;
        end
        state_next = ST_EVICT_OUT;
      end

      ST_EVICT_OUT: begin
        if (sts.out_free) begin
          cmd.emit       = 1'b1;
          cmd.emit_event = aqdp_pkg::EV_EVICTED;
          cmd.emit_src   = aqdp_pkg::SRC_MEM;
          state_next     = sts.drops_zero ? ST_ACCEPT : ST_EVICT_RD;
        end
      end

      ST_ACCEPT: begin
        if (sts.out_free) begin
          cmd.push       = 1'b1;
          cmd.emit       = 1'b1;
          cmd.emit_event = aqdp_pkg::EV_ACCEPTED;
          cmd.emit_last  = 1'b1;
          state_next     = ST_IDLE;
        end
      end

      ST_DISP_OUT: begin
        if (sts.out_free) begin
          cmd.emit       = 1'b1;
          cmd.emit_event = aqdp_pkg::EV_DISPATCHED;
          cmd.emit_src   = aqdp_pkg::SRC_MEM;
          cmd.emit_last  = 1'b1;
          state_next     = ST_IDLE;
        end
      end

      default: begin
        state_next = ST_IDLE;
      end
    endcase
  end

endmodule

// File: design/aqdp_datapath.sv
// Datapath of the admission queue: job memory, pointers, counters, LFSR and output register.
module aqdp_datapath #(
  parameter int unsigned QUEUE_DEPTH = 32,
  parameter int unsigned HANDLE_BITS = 16
) (
  input  logic                                clk,
  input  logic                                rst,
  input  aqdp_pkg::cmd_t                      cmd,
  output aqdp_pkg::sts_t                      sts,
  input  logic [aqdp_pkg::OP_W-1:0]           in_op,
  input  logic [aqdp_pkg::HANDLE_W-1:0]       in_handle,
  input  logic [aqdp_pkg::STAMP_W-1:0]        in_stamp,
  input  logic                                cfg_wen,
  input  logic [aqdp_pkg::CFG_IDX_W-1:0]      cfg_index,
  input  logic [aqdp_pkg::CFG_DATA_W-1:0]     cfg_data,
  output logic                                out_valid,
  input  logic                                out_ready,
  output logic [aqdp_pkg::EVENT_W-1:0]        out_event,
  output logic [aqdp_pkg::HANDLE_W-1:0]       out_handle,
  output logic [aqdp_pkg::STAMP_W-1:0]        out_stamp,
  output logic                                out_last,
  output logic [aqdp_pkg::COUNT_W-1:0]        waiting_now,
  output logic [aqdp_pkg::COUNT_W-1:0]        running_now
);

  localparam int unsigned HB = (HANDLE_BITS < aqdp_pkg::HANDLE_W) ?
                               HANDLE_BITS : aqdp_pkg::HANDLE_W;
  localparam int unsigned IW = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
  localparam int unsigned CW = $clog2(QUEUE_DEPTH + 1);
  localparam int unsigned SW = (CW + 1 > 7) ? CW + 1 : 7;
  localparam int unsigned EW = HB + aqdp_pkg::STAMP_W;

  // Held input transaction
  logic [aqdp_pkg::OP_W-1:0]    item_op;
  logic [HB-1:0]                item_handle;
  logic [aqdp_pkg::STAMP_W-1:0] item_stamp;

  always_ff @(posedge clk) begin
    if (cmd.load_item) begin
      item_op     <= in_op;
      item_handle <= in_handle[HB-1:0];
      item_stamp  <= in_stamp;
    end
  end

  // Configuration registers; a seed write loads the generator at once
  logic [aqdp_pkg::POLICY_W-1:0] policy;
  logic [aqdp_pkg::CAP_W-1:0]    capacity;
  logic [aqdp_pkg::LFSR_W-1:0]   lfsr;
  logic [aqdp_pkg::LFSR_W-1:0]   lfsr_next;

  assign lfsr_next = lfsr[0] ? ({1'b0, lfsr[aqdp_pkg::LFSR_W-1:1]} ^ aqdp_pkg::LFSR_MASK)
                             : {1'b0, lfsr[aqdp_pkg::LFSR_W-1:1]};

  always_ff @(posedge clk) begin
    if (rst) begin
      policy   <= aqdp_pkg::POLICY_BLOCK;
      capacity <= aqdp_pkg::CAPACITY_RESET;
      lfsr     <= aqdp_pkg::LFSR_RESET;
    end else begin
      if (cfg_wen && cfg_index == aqdp_pkg::REG_DROP_POLICY) begin
        policy <= cfg_data[aqdp_pkg::POLICY_W-1:0];
      end
      if (cfg_wen && cfg_index == aqdp_pkg::REG_CAPACITY) begin
        capacity <= cfg_data[aqdp_pkg::CAP_W-1:0];
      end
      if (cfg_wen && cfg_index == aqdp_pkg::REG_LFSR_SEED) begin
        lfsr <= cfg_data[aqdp_pkg::LFSR_W-1:0];
      end else if (cmd.lfsr_step) begin
        lfsr <= lfsr_next;
      end
    end
  end

  // Ring pointers and job counts
  logic [IW-1:0] head;
  logic [IW-1:0] tail;
  logic [IW-1:0] head_inc;
  logic [IW-1:0] tail_inc;
  logic [IW-1:0] tail_dec;
  logic [IW-1:0] head_next;
  logic [IW-1:0] tail_next;
  logic [CW-1:0] waiting;
  logic [CW-1:0] running;
  logic [CW-1:0] waiting_next;
  logic [CW-1:0] running_next;

  assign head_inc = (head == IW'(QUEUE_DEPTH - 1)) ? '0 : head + 1'b1;
  assign tail_inc = (tail == IW'(QUEUE_DEPTH - 1)) ? '0 : tail + 1'b1;
  assign tail_dec = (tail == '0) ? IW'(QUEUE_DEPTH - 1) : tail - 1'b1;

  always_comb begin
    head_next    = head;
    tail_next    = tail;
    waiting_next = waiting;
    running_next = running;
    if (cmd.push) begin
      tail_next    = tail_inc;
      waiting_next = waiting + 1'b1;
    end else if (cmd.pop) begin
      waiting_next = waiting - 1'b1;
      if (cmd.pop_tail) begin
        tail_next = tail_dec;
      end else begin
        head_next = head_inc;
      end
    end
    if (cmd.run_inc) begin
      running_next = running + 1'b1;
    end else if (cmd.run_dec) begin
      running_next = running - 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      head    <= '0;
      tail    <= '0;
      waiting <= '0;
      running <= '0;
    end else begin
      head    <= head_next;
      tail    <= tail_next;
      waiting <= waiting_next;
      running <= running_next;
    end
  end

  // Job memory: written at the tail, read at the head or just below the tail
  logic [EW-1:0] mem [QUEUE_DEPTH];
  logic [EW-1:0] rd_data;
  logic [IW-1:0] rd_addr;

  assign rd_addr = cmd.pop_tail ? tail_dec : head;

  always_ff @(posedge clk) begin
    if (cmd.push) begin
      mem[tail] <= {item_handle, item_stamp};
    end
    if (cmd.pop) begin
      rd_data <= mem[rd_addr];
    end
  end

  // Count of evictions still to do for the current arrival
  logic [CW-1:0] drops;
  logic [CW:0]   half_up;

  assign half_up = ({1'b0, waiting} + 1'b1) >> 1;

  always_ff @(posedge clk) begin
    if (cmd.load_drops) begin
      drops <= (policy == aqdp_pkg::POLICY_RANDOM) ? half_up[CW-1:0] : CW'(1);
    end else if (cmd.dec_drops) begin
      drops <= drops - 1'b1;
    end
  end

  // Admission check against the capacity, clamped to the ring depth
  logic [SW-1:0] load_sum;
  logic [SW-1:0] cap_eff;

  assign load_sum = SW'(waiting) + SW'(running);
  assign cap_eff  = (SW'(capacity) > SW'(QUEUE_DEPTH)) ? SW'(QUEUE_DEPTH) : SW'(capacity);

  assign sts.op           = item_op;
  assign sts.policy       = policy;
  assign sts.full         = (load_sum >= cap_eff) || (waiting >= CW'(QUEUE_DEPTH));
  assign sts.waiting_zero = (waiting == '0);
  assign sts.running_zero = (running == '0);
  assign sts.drops_zero   = (drops == '0);
  assign sts.lfsr_bit     = lfsr_next[0];
  assign sts.out_free     = !out_valid || out_ready;

  // Output register
  logic [HB-1:0]                src_handle;
  logic [aqdp_pkg::STAMP_W-1:0] src_stamp;

  always_comb begin
    unique case (cmd.emit_src)
      aqdp_pkg::SRC_ITEM: begin
        src_handle = item_handle;
        src_stamp  = item_stamp;
      end
      aqdp_pkg::SRC_MEM: begin
        src_handle = rd_data[EW-1:aqdp_pkg::STAMP_W];
        src_stamp  = rd_data[aqdp_pkg::STAMP_W-1:0];
      end
      default: begin
        src_handle = '0;
        src_stamp  = '0;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (cmd.emit) begin
      out_valid <= 1'b1;
    end else if (out_ready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.emit) begin
      out_event   <= cmd.emit_event;
      out_handle  <= aqdp_pkg::HANDLE_W'(src_handle);
      out_stamp   <= src_stamp;
      out_last    <= cmd.emit_last;
      waiting_now <= aqdp_pkg::COUNT_W'(waiting_next);
      running_now <= aqdp_pkg::COUNT_W'(running_next);
    end
  end

endmodule

// File: design/admission_queue_with_drop_policy_unit.sv
// Top level of the admission queue with drop policy.
// Jobs arrive, are dispatched and finish through one input stream; each input transaction
// with a used operation code gives one or more results, the last one marked by m_tlast. The
// block handles one input at a time and accepts the next one while a finished result still
// waits at the output. A dispatch passes through an extra state, since the job memory is
// read through a registered port. A full arrival with jobs waiting evicts one job under
// drop-oldest and ceil(waiting / 2) under random drop, one memory read and one result per
// eviction, before it is accepted. The job memory needs no clearing after reset. The user
// must write configuration only while the block is idle; the block does not enforce it.
module admission_queue_with_drop_policy_unit #(
  parameter int unsigned QUEUE_DEPTH = 32,
  parameter int unsigned HANDLE_BITS = 16
) (
  input  logic                                clk,
  input  logic                                rst,
  // Input stream
  input  logic                                s_tvalid,
  output logic                                s_tready,
  input  logic [aqdp_pkg::S_DATA_W-1:0]       s_tdata,  // job_handle[15:0], arrival_stamp[47:16]
  input  logic [aqdp_pkg::OP_W-1:0]           s_tuser,  // operation[1:0]
  // Result stream
  output logic                                m_tvalid,
  input  logic                                m_tready,
  output logic [aqdp_pkg::M_DATA_W-1:0]       m_tdata,  // out_handle[15:0], out_stamp[47:16],
                                                        // waiting_now[53:48],
                                                        // running_now[59:54], zero[63:60]
  output logic [aqdp_pkg::EVENT_W-1:0]        m_tuser,  // event_res[2:0]
  output logic                                m_tlast,
  // Configuration writes
  input  logic                                cfg_wen,
  input  logic [aqdp_pkg::CFG_IDX_W-1:0]      cfg_index,
  input  logic [aqdp_pkg::CFG_DATA_W-1:0]     cfg_data
);

  aqdp_pkg::cmd_t cmd;
  aqdp_pkg::sts_t sts;

  logic [aqdp_pkg::HANDLE_W-1:0] out_handle;
  logic [aqdp_pkg::STAMP_W-1:0]  out_stamp;
  logic [aqdp_pkg::COUNT_W-1:0]  waiting_now;
  logic [aqdp_pkg::COUNT_W-1:0]  running_now;

  // Sequencing of each transaction
  aqdp_ctrl u_ctrl (
    .clk      (clk),
    .rst      (rst),
    .in_valid (s_tvalid),
    .in_ready (s_tready),
    .sts      (sts),
    .cmd      (cmd)
  );

  // Storage, counters and output register
  aqdp_datapath #(
    .QUEUE_DEPTH (QUEUE_DEPTH),
    .HANDLE_BITS (HANDLE_BITS)
  ) u_datapath (
    .clk         (clk),
    .rst         (rst),
    .cmd         (cmd),
    .sts         (sts),
    .in_op       (s_tuser),
    .in_handle   (s_tdata[aqdp_pkg::HANDLE_W-1:0]),
    .in_stamp    (s_tdata[aqdp_pkg::HANDLE_W +: aqdp_pkg::STAMP_W]),
    .cfg_wen     (cfg_wen),
    .cfg_index   (cfg_index),
    .cfg_data    (cfg_data),
    .out_valid   (m_tvalid),
    .out_ready   (m_tready),
    .out_event   (m_tuser),
    .out_handle  (out_handle),
    .out_stamp   (out_stamp),
    .out_last    (m_tlast),
    .waiting_now (waiting_now),
    .running_now (running_now)
  );

  // Pack the result fields, lowest first
  assign m_tdata = {4'b0000, running_now, waiting_now, out_stamp, out_handle};

endmodule

// File: design/aqdp_checker.sv
// Port-level checks of the admission queue, bound to its top level.
module aqdp_checker #(
  parameter int unsigned QUEUE_DEPTH = 32
) (
  input logic                            clk,
  input logic                            rst,
  input logic                            s_tready,
  input logic                            m_tvalid,
  input logic                            m_tready,
  input logic [aqdp_pkg::M_DATA_W-1:0]   m_tdata,
  input logic [aqdp_pkg::EVENT_W-1:0]    m_tuser,
  input logic                            m_tlast
);

  // A stalled result transaction holds its payload
  a_hold: assert property (@(posedge clk) disable iff (rst)
    m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata) && $stable(m_tuser)
                              && $stable(m_tlast))
    else $error("result changed while stalled");

  // Waiting plus running never exceeds the ring depth
  a_load: assert property (@(posedge clk) disable iff (rst)
    m_tvalid |-> ({1'b0, m_tdata[53:48]} + {1'b0, m_tdata[59:54]}) <= 7'(QUEUE_DEPTH))
    else $error("job load above ring depth");

  // An empty dispatch reports no waiting job and a zero payload
  a_empty: assert property (@(posedge clk) disable iff (rst)
    m_tvalid && m_tuser == aqdp_pkg::EV_EMPTY |->
      m_tdata[53:48] == '0 && m_tdata[47:0] == '0)
    else $error("empty result with waiting jobs or payload");

  // A finish error only happens with nothing running
  a_fin_err: assert property (@(posedge clk) disable iff (rst)
    m_tvalid && m_tuser == aqdp_pkg::EV_FINISH_ERROR |-> m_tdata[59:54] == '0)
    else $error("finish error with running jobs");

  // While an eviction that is not the final result is shown, no new input is taken
  a_busy: assert property (@(posedge clk) disable iff (rst)
    m_tvalid && !m_tlast |-> !s_tready)
    else $error("input taken before the final result of a transaction");

endmodule

bind admission_queue_with_drop_policy_unit aqdp_checker #(
  .QUEUE_DEPTH (QUEUE_DEPTH)
) u_aqdp_checker (
  .clk      (clk),
  .rst      (rst),
  .s_tready (s_tready),
  .m_tvalid (m_tvalid),
  .m_tready (m_tready),
  .m_tdata  (m_tdata),
  .m_tuser  (m_tuser),
  .m_tlast  (m_tlast)
);

// File: tb/admission_queue_with_drop_policy_unit_tb.sv
// Self-checking testbench of the admission queue with drop policy: directed and random job traffic.
module admission_queue_with_drop_policy_unit_tb;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int unsigned QDEPTH        = 32;
  localparam int unsigned SETTLE_CYCLES = 50;
  localparam int unsigned LONG_HOLD     = 300;
  localparam int unsigned PHASES        = 12;
  localparam int unsigned PHASE_OPS     = 40;

  // Bit positions of the result fields inside m_tdata
  localparam int unsigned STAMP_LSB = aqdp_pkg::HANDLE_W;
  localparam int unsigned WAIT_LSB  = STAMP_LSB + aqdp_pkg::STAMP_W;
  localparam int unsigned RUN_LSB   = WAIT_LSB + aqdp_pkg::COUNT_W;
  localparam int unsigned PAD_LSB   = RUN_LSB + aqdp_pkg::COUNT_W;

  // The one operation code that the block ignores
  localparam logic [aqdp_pkg::OP_W-1:0] OP_IGNORED = 2'd3;

  typedef struct packed {
    logic [aqdp_pkg::OP_W-1:0]     op;
    logic [aqdp_pkg::HANDLE_W-1:0] handle;
    logic [aqdp_pkg::STAMP_W-1:0]  stamp;
  } job_op_t;

  typedef struct packed {
    logic [aqdp_pkg::EVENT_W-1:0]  ev;
    logic [aqdp_pkg::HANDLE_W-1:0] handle;
    logic [aqdp_pkg::STAMP_W-1:0]  stamp;
    logic                          last;
    logic [aqdp_pkg::COUNT_W-1:0]  waiting;
    logic [aqdp_pkg::COUNT_W-1:0]  running;
  } job_event_t;

  logic                            clk = 1'b0;
  logic                            rst = 1'b1;
  logic                            s_tvalid = 1'b0;
  logic                            s_tready;
  logic [aqdp_pkg::S_DATA_W-1:0]   s_tdata = '0;
  logic [aqdp_pkg::OP_W-1:0]       s_tuser = '0;
  logic                            m_tvalid;
  logic                            m_tready = 1'b0;
  logic [aqdp_pkg::M_DATA_W-1:0]   m_tdata;
  logic [aqdp_pkg::EVENT_W-1:0]    m_tuser;
  logic                            m_tlast;
  logic                            cfg_wen = 1'b0;
  logic [aqdp_pkg::CFG_IDX_W-1:0]  cfg_index = '0;
  logic [aqdp_pkg::CFG_DATA_W-1:0] cfg_data = '0;

  admission_queue_with_drop_policy_unit #(
    .QUEUE_DEPTH(QDEPTH),
    .HANDLE_BITS(aqdp_pkg::HANDLE_W)
  ) dut (
    .clk      (clk),
    .rst      (rst),
    .s_tvalid (s_tvalid),
    .s_tready (s_tready),
    .s_tdata  (s_tdata),
    .s_tuser  (s_tuser),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata),
    .m_tuser  (m_tuser),
    .m_tlast  (m_tlast),
    .cfg_wen  (cfg_wen),
    .cfg_index(cfg_index),
    .cfg_data (cfg_data)
  );

  // Job operations still to be sent and events the block still owes
  job_op_t    job_ops_to_send[$];
  job_event_t events_due[$];
  job_op_t    offered_op;
  int unsigned mismatch_count = 0;

  // Handshake pacing, set per phase by the stimulus
  int unsigned send_idle_pct = 0;
  int unsigned stall_pct     = 0;
  int unsigned burst_req     = 0;
  int unsigned burst_seen    = 0;
  int unsigned hold_left     = 0;

  // Shadow copy of the queue state and the configuration
  logic [aqdp_pkg::HANDLE_W-1:0] slot_handle [QDEPTH];
  logic [aqdp_pkg::STAMP_W-1:0]  slot_stamp  [QDEPTH];
  logic [$clog2(QDEPTH)-1:0]     head_ptr = '0;
  logic [$clog2(QDEPTH)-1:0]     tail_ptr = '0;
  int unsigned                   n_waiting = 0;
  int unsigned                   n_running = 0;
  logic [aqdp_pkg::LFSR_W-1:0]   lfsr_state = aqdp_pkg::LFSR_RESET;
  logic [aqdp_pkg::POLICY_W-1:0] policy_reg = aqdp_pkg::POLICY_BLOCK;
  logic [aqdp_pkg::CAP_W-1:0]    capacity_reg = aqdp_pkg::CAPACITY_RESET;

  initial forever #2 clk = ~clk;

  // Records one event with the counts as they stand after it.
  function automatic void note_event(logic [aqdp_pkg::EVENT_W-1:0] ev,
                                     logic [aqdp_pkg::HANDLE_W-1:0] h,
                                     logic [aqdp_pkg::STAMP_W-1:0] s, logic last);
    job_event_t e;
    e.ev      = ev;
    e.handle  = h;
    e.stamp   = s;
    e.last    = last;
    e.waiting = n_waiting[aqdp_pkg::COUNT_W-1:0];
    e.running = n_running[aqdp_pkg::COUNT_W-1:0];
    events_due.push_back(e);
  endfunction

  // Galois step; the new low bit picks the end of the ring to evict from.
  function automatic logic lfsr_advance();
    logic fb;
    fb = lfsr_state[0];
    lfsr_state = lfsr_state >> 1;
    if (fb) begin
      lfsr_state = lfsr_state ^ aqdp_pkg::LFSR_MASK;
    end
    return lfsr_state[0];
  endfunction

  function automatic void take_head(output logic [aqdp_pkg::HANDLE_W-1:0] h,
                                    output logic [aqdp_pkg::STAMP_W-1:0] s);
    h = slot_handle[head_ptr];
    s = slot_stamp[head_ptr];
    head_ptr = head_ptr + 1'b1;
    n_waiting--;
  endfunction

  function automatic void take_tail(output logic [aqdp_pkg::HANDLE_W-1:0] h,
                                    output logic [aqdp_pkg::STAMP_W-1:0] s);
    tail_ptr = tail_ptr - 1'b1;
    n_waiting--;
    h = slot_handle[tail_ptr];
    s = slot_stamp[tail_ptr];
  endfunction

  // Works out the events one accepted operation causes and updates the shadow state.
  function automatic void apply_job_op(job_op_t j);
    int unsigned                   cap;
    int unsigned                   drops;
    int unsigned                   i;
    logic                          full;
    logic                          from_tail;
    logic [aqdp_pkg::HANDLE_W-1:0] h;
    logic [aqdp_pkg::STAMP_W-1:0]  s;
    cap = 32'(capacity_reg);
    if (cap > QDEPTH) begin
      cap = QDEPTH;
    end
    case (j.op)
      aqdp_pkg::OP_ARRIVE: begin
        full = (n_waiting + n_running >= cap) || (n_waiting >= QDEPTH);
        if (full && policy_reg == aqdp_pkg::POLICY_BLOCK) begin
          note_event(aqdp_pkg::EV_FULL_RETRY, j.handle, j.stamp, 1'b1);
        end else if (full && (n_waiting == 0 || policy_reg == aqdp_pkg::POLICY_DROP_NEW)) begin
          note_event(aqdp_pkg::EV_REJECTED, j.handle, j.stamp, 1'b1);
        end else begin
          // Make room first: one head eviction, or half the waiting jobs, rounded up, from random ends
          if (full) begin
            drops = (policy_reg == aqdp_pkg::POLICY_RANDOM) ? (n_waiting + 1) / 2 : 1;
            for (i = 0; i < drops; i++) begin
              from_tail = 1'b0;
              if (policy_reg == aqdp_pkg::POLICY_RANDOM) begin
                from_tail = lfsr_advance();
              end
              if (from_tail) begin
                take_tail(h, s);
              end else begin
                take_head(h, s);
              end
              note_event(aqdp_pkg::EV_EVICTED, h, s, 1'b0);
            end
          end
          slot_handle[tail_ptr] = j.handle;
          slot_stamp[tail_ptr]  = j.stamp;
          tail_ptr = tail_ptr + 1'b1;
          n_waiting++;
          note_event(aqdp_pkg::EV_ACCEPTED, j.handle, j.stamp, 1'b1);
        end
      end
      aqdp_pkg::OP_REQUEST: begin
        if (n_waiting == 0) begin
          note_event(aqdp_pkg::EV_EMPTY, '0, '0, 1'b1);
        end else begin
          take_head(h, s);
          n_running++;
          note_event(aqdp_pkg::EV_DISPATCHED, h, s, 1'b1);
        end
      end
      aqdp_pkg::OP_FINISH: begin
        if (n_running == 0) begin
          note_event(aqdp_pkg::EV_FINISH_ERROR, '0, '0, 1'b1);
        end else begin
          n_running--;
          note_event(aqdp_pkg::EV_FINISHED, '0, '0, 1'b1);
        end
      end
      default: ;
    endcase
  endfunction

  function automatic void compare_field(string name, longint unsigned want,
                                        longint unsigned got);
    if (want != got) begin
      mismatch_count++;
      $display("%0t ns: %s differs, expected 0x%0h, actual 0x%0h", $time, name, want, got);
    end
  endfunction

  // Compares the result transaction on the bus with the oldest owed event.
  function automatic void check_result();
    job_event_t want;
    if (events_due.size() == 0) begin
      mismatch_count++;
      $display("%0t ns: result with none owed, expected nothing, actual event %0d data 0x%0h",
               $time, m_tuser, m_tdata);
    end else begin
      want = events_due.pop_front();
      compare_field("event", 64'(want.ev), 64'(m_tuser));
      compare_field("handle", 64'(want.handle), 64'(m_tdata[STAMP_LSB-1:0]));
      compare_field("stamp", 64'(want.stamp), 64'(m_tdata[WAIT_LSB-1:STAMP_LSB]));
      compare_field("waiting count", 64'(want.waiting), 64'(m_tdata[RUN_LSB-1:WAIT_LSB]));
      compare_field("running count", 64'(want.running), 64'(m_tdata[PAD_LSB-1:RUN_LSB]));
      compare_field("padding", 64'(0), 64'(m_tdata[aqdp_pkg::M_DATA_W-1:PAD_LSB]));
      compare_field("last flag", 64'(want.last), 64'(m_tlast));
    end
  endfunction

  function automatic job_op_t random_job_op(int unsigned arrive_pct, int unsigned request_pct);
    job_op_t     j;
    int unsigned r;
    r = $urandom_range(99);
    if (r < arrive_pct) begin
      j.op = aqdp_pkg::OP_ARRIVE;
    end else if (r < arrive_pct + request_pct) begin
      j.op = aqdp_pkg::OP_REQUEST;
    end else if (r < 97) begin
      j.op = aqdp_pkg::OP_FINISH;
    end else begin
      j.op = OP_IGNORED;
    end
    j.handle = aqdp_pkg::HANDLE_W'($urandom_range(16'hFFFF));
    j.stamp  = $urandom();
    return j;
  endfunction

  function automatic void queue_op(logic [aqdp_pkg::OP_W-1:0] op,
                                   logic [aqdp_pkg::HANDLE_W-1:0] h,
                                   logic [aqdp_pkg::STAMP_W-1:0] s);
    job_op_t j;
    j.op     = op;
    j.handle = h;
    j.stamp  = s;
    job_ops_to_send.push_back(j);
  endfunction

  // Register write while the block is idle; the shadow follows at once.
  task automatic write_reg(logic [aqdp_pkg::CFG_IDX_W-1:0] idx,
                           logic [aqdp_pkg::CFG_DATA_W-1:0] value);
    @(posedge clk);
    cfg_wen   <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= value;
    @(posedge clk);
    cfg_wen <= 1'b0;
    case (idx)
      aqdp_pkg::REG_DROP_POLICY: policy_reg = value[aqdp_pkg::POLICY_W-1:0];
      aqdp_pkg::REG_CAPACITY:    capacity_reg = value[aqdp_pkg::CAP_W-1:0];
      aqdp_pkg::REG_LFSR_SEED:   lfsr_state = value[aqdp_pkg::LFSR_W-1:0];
      default: ;
    endcase
    @(negedge clk);
  endtask

  task automatic wait_drained();
    do @(negedge clk);
    while (job_ops_to_send.size() != 0 || s_tvalid || events_due.size() != 0);
  endtask

  // Ops that cause no result may still be in progress, so allow for the latency too.
  task automatic settle();
    wait_drained();
    repeat (SETTLE_CYCLES) @(negedge clk);
  endtask

  // Driver: offers the next pending operation once the previous transaction is taken
  always @(posedge clk) begin
    if (rst) begin
      s_tvalid <= 1'b0;
    end else begin
      if (s_tvalid && s_tready) begin
        apply_job_op(offered_op);
      end
      if (!s_tvalid || s_tready) begin
        if (job_ops_to_send.size() != 0 && $urandom_range(99) >= send_idle_pct) begin
          offered_op = job_ops_to_send.pop_front();
          s_tvalid <= 1'b1;
          s_tdata  <= {offered_op.stamp, offered_op.handle};
          s_tuser  <= offered_op.op;
        end else begin
          s_tvalid <= 1'b0;
        end
      end
    end
  end

  // Monitor: checks each result transaction and paces m_tready
  always @(posedge clk) begin
    if (rst) begin
      m_tready <= 1'b0;
    end else begin
      if (m_tvalid && m_tready) begin
        check_result();
      end
      if (burst_req != burst_seen) begin
        burst_seen = burst_req;
        hold_left  = LONG_HOLD;
      end
      if (hold_left != 0) begin
        hold_left--;
        m_tready <= 1'b0;
      end else begin
        m_tready <= ($urandom_range(99) >= stall_pct);
      end
    end
  end

  // Stimulus: directed cases, then random phases under varied settings and pacing
  initial begin
    job_op_t                       j;
    int unsigned                   ph;
    int unsigned                   sent;
    int unsigned                   arrive_pct;
    int unsigned                   request_pct;
    logic [aqdp_pkg::CAP_W-1:0]    cap;
    logic [aqdp_pkg::POLICY_W-1:0] policy;
    repeat (10) @(posedge clk);
    rst <= 1'b0;
    @(negedge clk);

    // Empty dispatch, finish with nothing running, ignored op, extreme field values
    queue_op(aqdp_pkg::OP_REQUEST, '0, '0);
    queue_op(aqdp_pkg::OP_FINISH, '0, '0);
    queue_op(OP_IGNORED, 16'hFFFF, 32'hFFFF_FFFF);
    queue_op(aqdp_pkg::OP_ARRIVE, 16'hFFFF, 32'hFFFF_FFFF);
    queue_op(aqdp_pkg::OP_ARRIVE, 16'h0000, 32'h0000_0000);
    queue_op(aqdp_pkg::OP_REQUEST, '0, '0);
    queue_op(aqdp_pkg::OP_FINISH, '0, '0);
    settle();

    // Small capacity: full retry under block, rejection under drop-new, eviction under drop-oldest
    write_reg(aqdp_pkg::REG_CAPACITY, 16'd2);
    queue_op(aqdp_pkg::OP_ARRIVE, 16'h1234, 32'h5555_AAAA);
    queue_op(aqdp_pkg::OP_ARRIVE, 16'h4321, 32'hAAAA_5555);
    settle();
    write_reg(aqdp_pkg::REG_DROP_POLICY, aqdp_pkg::CFG_DATA_W'(aqdp_pkg::POLICY_DROP_NEW));
    queue_op(aqdp_pkg::OP_ARRIVE, 16'h0F0F, 32'h0F0F_0F0F);
    settle();
    write_reg(aqdp_pkg::REG_DROP_POLICY, aqdp_pkg::CFG_DATA_W'(aqdp_pkg::POLICY_DROP_HEAD));
    queue_op(aqdp_pkg::OP_ARRIVE, 16'hA5A5, 32'hDEAD_0001);
    settle();

    // Capacity lowered below the load, random drop with a zero seed, then a fresh seed
    write_reg(aqdp_pkg::REG_DROP_POLICY, aqdp_pkg::CFG_DATA_W'(aqdp_pkg::POLICY_RANDOM));
    write_reg(aqdp_pkg::REG_CAPACITY, 16'd1);
    write_reg(aqdp_pkg::REG_LFSR_SEED, 16'h0000);
    queue_op(aqdp_pkg::OP_ARRIVE, 16'h5A5A, 32'hDEAD_0002);
    settle();
    write_reg(aqdp_pkg::REG_LFSR_SEED, 16'h8001);
    queue_op(aqdp_pkg::OP_ARRIVE, 16'hC3C3, 32'hDEAD_0003);
    settle();

    // Capacity zero: drop-oldest still admits, but with nothing waiting the job is rejected
    write_reg(aqdp_pkg::REG_DROP_POLICY, aqdp_pkg::CFG_DATA_W'(aqdp_pkg::POLICY_DROP_HEAD));
    write_reg(aqdp_pkg::REG_CAPACITY, 16'd0);
    queue_op(aqdp_pkg::OP_ARRIVE, 16'h3C3C, 32'hDEAD_0004);
    queue_op(aqdp_pkg::OP_REQUEST, '0, '0);
    queue_op(aqdp_pkg::OP_REQUEST, '0, '0);
    queue_op(aqdp_pkg::OP_ARRIVE, 16'h7E7E, 32'hDEAD_0005);
    settle();

    // Capacity above the ring depth
    write_reg(aqdp_pkg::REG_DROP_POLICY, aqdp_pkg::CFG_DATA_W'(aqdp_pkg::POLICY_BLOCK));
    write_reg(aqdp_pkg::REG_CAPACITY, 16'd63);
    queue_op(aqdp_pkg::OP_FINISH, '0, '0);
    queue_op(aqdp_pkg::OP_FINISH, '0, '0);
    queue_op(aqdp_pkg::OP_ARRIVE, 16'h8001, 32'h8000_0001);
    queue_op(aqdp_pkg::OP_REQUEST, '0, '0);
    queue_op(aqdp_pkg::OP_FINISH, '0, '0);

    for (ph = 0; ph < PHASES; ph++) begin
      settle();
      case (ph % 4)
        0: begin
          send_idle_pct = 0;
          stall_pct     = 0;
        end
        1: begin
          send_idle_pct = 81;
          stall_pct     = 0;
        end
        2: begin
          send_idle_pct = 0;
          stall_pct     = 81;
        end
        default: begin
          send_idle_pct = 26;
          stall_pct     = 26;
        end
      endcase
      case ((ph + ph / 4) % 4)
        0:       policy = aqdp_pkg::POLICY_BLOCK;
        1:       policy = aqdp_pkg::POLICY_DROP_NEW;
        2:       policy = aqdp_pkg::POLICY_DROP_HEAD;
        default: policy = aqdp_pkg::POLICY_RANDOM;
      endcase
      case (ph)
        0:       cap = 6'd4;
        1:       cap = 6'd2;
        2:       cap = 6'd8;
        3:       cap = 6'd32;
        4:       cap = 6'd1;
        5:       cap = 6'd63;
        6:       cap = 6'd16;
        7:       cap = 6'd0;
        8:       cap = 6'd3;
        9:       cap = 6'd33;
        10:      cap = 6'd6;
        default: cap = aqdp_pkg::CAP_W'($urandom_range(1, 63));
      endcase
      write_reg(aqdp_pkg::REG_DROP_POLICY, aqdp_pkg::CFG_DATA_W'(policy));
      write_reg(aqdp_pkg::REG_CAPACITY, aqdp_pkg::CFG_DATA_W'(cap));
      write_reg(aqdp_pkg::REG_LFSR_SEED,
                (ph == 9) ? 16'h0000 : 16'($urandom_range(1, 65535)));
      case (ph % 3)
        0: begin
          arrive_pct  = 70;
          request_pct = 15;
        end
        1: begin
          arrive_pct  = 50;
          request_pct = 25;
        end
        default: begin
          arrive_pct  = 35;
          request_pct = 35;
        end
      endcase
      // First phase: hold the result side off so the block backs up onto its input
      if (ph == 0) begin
        burst_req++;
      end
      sent = 0;
      while (sent < PHASE_OPS) begin
        j = random_job_op(arrive_pct, request_pct);
        job_ops_to_send.push_back(j);
        if (j.op != OP_IGNORED) begin
          sent++;
          // Halfway through, pause the sender until every owed result has come back
          if (sent == PHASE_OPS / 2) begin
            wait_drained();
          end
        end
      end
    end

    settle();
    if (mismatch_count == 0) begin
      $display("No mismatches found");
    end else begin
      $display("Mismatches found");
    end
    $finish;
  end

  // Watchdog on the whole run
  initial begin
    #2_000_000;
    $display("Mismatches found");
    $finish;
  end

endmodule
